// ===== hdl/rnps_pkg.sv =====
// Shared types, widths and register codes for the ROI nearest point select unit.
// No dependencies; every other file imports this package.
package rnps_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH   = SQ_WIDTH + 2;
    localparam int RANGE_WIDTH = 32;
    localparam int CMP_WIDTH   = (SUM_WIDTH > RANGE_WIDTH) ? SUM_WIDTH : RANGE_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [SQ_WIDTH-1:0]    square_t;
    typedef logic        [SUM_WIDTH-1:0]   range_sum_t;
    typedef logic        [RANGE_WIDTH-1:0] range_t;
    typedef logic        [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    // Register indexes on the configuration port
    localparam cfg_index_t CFG_X_LOW  = 3'd0;
    localparam cfg_index_t CFG_X_HIGH = 3'd1;
    localparam cfg_index_t CFG_Y_LOW  = 3'd2;
    localparam cfg_index_t CFG_Y_HIGH = 3'd3;
    localparam cfg_index_t CFG_Z_LOW  = 3'd4;
    localparam cfg_index_t CFG_Z_HIGH = 3'd5;

    // Bound values after reset (Q8.7 metres)
    localparam coord_t RST_X_LOW  = COORD_WIDTH'(128);
    localparam coord_t RST_X_HIGH = COORD_WIDTH'(640);
    localparam coord_t RST_Y_LOW  = COORD_WIDTH'(-128);
    localparam coord_t RST_Y_HIGH = COORD_WIDTH'(128);
    localparam coord_t RST_Z_LOW  = COORD_WIDTH'(-256);
    localparam coord_t RST_Z_HIGH = COORD_WIDTH'(0);

    localparam range_t NOT_FOUND_RANGE = 32'hFFFF_FFFF;
    localparam range_t MAX_FOUND_RANGE = 32'hFFFF_FFFE;

    typedef struct packed {
        coord_t x_low;
        coord_t x_high;
        coord_t y_low;
        coord_t y_high;
        coord_t z_low;
        coord_t z_high;
    } box_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
    } point_word_t;

    // Candidate word between the square stage and the tracker
    typedef struct packed {
        logic    valid;
        logic    in_box;
        logic    last;
        coord_t  x;
        coord_t  y;
        coord_t  z;
        square_t sq_x;
        square_t sq_y;
        square_t sq_z;
    } cand_t;

    typedef struct packed {
        logic   found;
        coord_t near_x;
        coord_t near_y;
        coord_t near_z;
        range_t range_squared;
    } result_word_t;

endpackage

// ===== hdl/rnps_if.sv =====
// Valid/ready channel interfaces: point input, result output, configuration write.
// Depends on rnps_pkg.
interface rnps_point_if
    import rnps_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   scan_end;

    modport source (output valid, point_x, point_y, point_z, scan_end, input ready);
    modport sink   (input valid, point_x, point_y, point_z, scan_end, output ready);
endinterface

interface rnps_result_if
    import rnps_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   found;
    coord_t near_x;
    coord_t near_y;
    coord_t near_z;
    range_t range_squared;

    modport source (output valid, found, near_x, near_y, near_z, range_squared, input ready);
    modport sink   (input valid, found, near_x, near_y, near_z, range_squared, output ready);
endinterface

interface rnps_cfg_if
    import rnps_pkg::*;
;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    coord_t     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/roi_nearest_point_select_unit.sv =====
// ROI nearest point select: box crop and closest-point search over a lidar scan.
// Path: a scan's last point passes the input register, the square stage and the
// tracker/result register before its result is valid.
// Throughput: one point per cycle; a waiting result stalls input only when the
// next last point reaches the tracker. Reset sets the default box and clears the
// search; no clearing pass. Depends on rnps_pkg, rnps_if and the rnps_* modules.
module roi_nearest_point_select_unit
    import rnps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rnps_point_if.sink    point,
    rnps_result_if.source result,
    rnps_cfg_if.sink      cfg
);

    logic         in_valid_reg;
    point_word_t  in_word_reg;
    logic         stage_ready;
    box_t         box;
    cand_t        cand;
    logic         cand_ready;
    logic         res_valid;
    result_word_t res;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    rnps_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .box      (box)
    );

    // Input register: capture a point word whenever the next stage moves
    assign point.ready = !in_valid_reg || stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (point.ready)
        begin
            in_valid_reg <= point.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (point.ready && point.valid)
        begin
            in_word_reg.x    <= point.point_x;
            in_word_reg.y    <= point.point_y;
            in_word_reg.z    <= point.point_z;
            in_word_reg.last <= point.scan_end;
        end
    end

    rnps_square_stage u_square_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid_reg),
        .in_ready   (stage_ready),
        .in_word    (in_word_reg),
        .box        (box),
        .cand       (cand),
        .cand_ready (cand_ready)
    );

    rnps_best_track u_best_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand       (cand),
        .cand_ready (cand_ready),
        .res_valid  (res_valid),
        .res_ready  (result.ready),
        .res        (res)
    );

    // Drive the result channel
    assign result.valid         = res_valid;
    assign result.found         = res.found;
    assign result.near_x        = res.near_x;
    assign result.near_y        = res.near_y;
    assign result.near_z        = res.near_z;
    assign result.range_squared = res.range_squared;

endmodule

// ===== hdl/rnps_cfg_regs.sv =====
// Box bound registers written through the configuration port.
// Depends on rnps_pkg.
module rnps_cfg_regs
    import rnps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  cfg_index_t wr_index,
    input  coord_t     wr_data,
    output box_t       box
);

    box_t box_reg;
    box_t box_next;

    // Decode the index; unknown indexes leave the bounds alone
    always_comb
    begin
        box_next = box_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_X_LOW:  box_next.x_low  = wr_data;
                CFG_X_HIGH: box_next.x_high = wr_data;
                CFG_Y_LOW:  box_next.y_low  = wr_data;
                CFG_Y_HIGH: box_next.y_high = wr_data;
                CFG_Z_LOW:  box_next.z_low  = wr_data;
                CFG_Z_HIGH: box_next.z_high = wr_data;
                default:    box_next = box_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.x_low  <= RST_X_LOW;
            box_reg.x_high <= RST_X_HIGH;
            box_reg.y_low  <= RST_Y_LOW;
            box_reg.y_high <= RST_Y_HIGH;
            box_reg.z_low  <= RST_Z_LOW;
            box_reg.z_high <= RST_Z_HIGH;
        end
        else
        begin
            box_reg <= box_next;
        end
    end

    assign box = box_reg;

endmodule

// ===== hdl/rnps_square_stage.sv =====
// Box test and per-axis squares, registered into a candidate word.
// Depends on rnps_pkg.
module rnps_square_stage
    import rnps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  point_word_t in_word,
    input  box_t        box,
    output cand_t       cand,
    input  logic        cand_ready
);

    cand_t cand_reg;
    cand_t cand_next;
    logic  advance;

    logic [COORD_WIDTH-1:0] mag_x;
    logic [COORD_WIDTH-1:0] mag_y;
    logic [COORD_WIDTH-1:0] mag_z;

    assign advance  = !cand_reg.valid || cand_ready;
    assign in_ready = advance;

    // Take magnitudes; the most negative code maps to its unsigned magnitude
    always_comb
    begin
        mag_x = in_word.x[COORD_WIDTH-1] ? COORD_WIDTH'(~in_word.x + 1'b1)
                                         : COORD_WIDTH'(in_word.x);
        mag_y = in_word.y[COORD_WIDTH-1] ? COORD_WIDTH'(~in_word.y + 1'b1)
                                         : COORD_WIDTH'(in_word.y);
        mag_z = in_word.z[COORD_WIDTH-1] ? COORD_WIDTH'(~in_word.z + 1'b1)
                                         : COORD_WIDTH'(in_word.z);
    end

    // Form the candidate word: inclusive box test and squares
    always_comb
    begin
        cand_next.valid  = in_valid;
        cand_next.in_box = (in_word.x >= box.x_low) && (in_word.x <= box.x_high) &&
                           (in_word.y >= box.y_low) && (in_word.y <= box.y_high) &&
                           (in_word.z >= box.z_low) && (in_word.z <= box.z_high);
        cand_next.last   = in_word.last;
        cand_next.x      = in_word.x;
        cand_next.y      = in_word.y;
        cand_next.z      = in_word.z;
        cand_next.sq_x   = SQ_WIDTH'(mag_x) * SQ_WIDTH'(mag_x);
        cand_next.sq_y   = SQ_WIDTH'(mag_y) * SQ_WIDTH'(mag_y);
        cand_next.sq_z   = SQ_WIDTH'(mag_z) * SQ_WIDTH'(mag_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else if (advance)
        begin
            cand_reg <= cand_next;
        end
    end

    assign cand = cand_reg;

endmodule

// ===== hdl/rnps_best_track.sv =====
// Closest-point tracker and result register.
// Depends on rnps_pkg; fed by rnps_square_stage.
module rnps_best_track
    import rnps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cand_t        cand,
    output logic         cand_ready,
    output logic         res_valid,
    input  logic         res_ready,
    output result_word_t res
);

    logic         have_reg;
    range_sum_t   best_sum_reg;
    coord_t       best_x_reg;
    coord_t       best_y_reg;
    coord_t       best_z_reg;
    logic         res_valid_reg;
    result_word_t res_reg;

    range_sum_t   sum;
    logic         better;
    logic         have_next;
    range_sum_t   best_sum_next;
    coord_t       best_x_next;
    coord_t       best_y_next;
    coord_t       best_z_next;
    logic         fire;
    result_word_t res_next;

    // Only a last word needs room in the result register
    assign cand_ready = !cand.valid || !cand.last || !res_valid_reg || res_ready;
    assign fire       = cand.valid && cand_ready;

    // Compare and update; ties keep the earlier point
    always_comb
    begin
        sum = SUM_WIDTH'(cand.sq_x) + SUM_WIDTH'(cand.sq_y) + SUM_WIDTH'(cand.sq_z);
        better = cand.valid && cand.in_box && (!have_reg || (sum < best_sum_reg));
        have_next     = have_reg || (cand.valid && cand.in_box);
        best_sum_next = better ? sum    : best_sum_reg;
        best_x_next   = better ? cand.x : best_x_reg;
        best_y_next   = better ? cand.y : best_y_reg;
        best_z_next   = better ? cand.z : best_z_reg;
    end

    // Build the result word, saturating the range below the not-found code
    always_comb
    begin
        res_next.found  = have_next;
        res_next.near_x = best_x_next;
        res_next.near_y = best_y_next;
        res_next.near_z = best_z_next;
        if (!have_next)
        begin
            res_next.range_squared = NOT_FOUND_RANGE;
        end
        else if (CMP_WIDTH'(best_sum_next) > CMP_WIDTH'(MAX_FOUND_RANGE))
        begin
            res_next.range_squared = MAX_FOUND_RANGE;
        end
        else
        begin
            res_next.range_squared = RANGE_WIDTH'(best_sum_next);
        end
    end

    // Hold search state; clear it after the last point of a scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg     <= 1'b0;
            best_sum_reg <= '1;
            best_x_reg   <= '0;
            best_y_reg   <= '0;
            best_z_reg   <= '0;
        end
        else if (fire)
        begin
            if (cand.last)
            begin
                have_reg     <= 1'b0;
                best_sum_reg <= '1;
                best_x_reg   <= '0;
                best_y_reg   <= '0;
                best_z_reg   <= '0;
            end
            else
            begin
                have_reg     <= have_next;
                best_sum_reg <= best_sum_next;
                best_x_reg   <= best_x_next;
                best_y_reg   <= best_y_next;
                best_z_reg   <= best_z_next;
            end
        end
    end

    // Result register: load on a last word, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire && cand.last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && cand.last)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cand.last) |=> (!have_reg && best_x_reg == '0))
        else $error("search state not cleared after last point");

    a_not_found_code: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.found) |->
            (res_reg.range_squared == NOT_FOUND_RANGE && res_reg.near_x == '0))
        else $error("not-found result carries data");

    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.found) |-> (res_reg.range_squared != NOT_FOUND_RANGE))
        else $error("found result uses the not-found range code");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(have_reg) && $stable(best_sum_reg)))
        else $error("search state moved without a word");

endmodule
